// ===== src/bais_pkg.sv =====
// shared types, constants and the divider step for the block-aligned splitter
package bais_pkg;

  localparam int DIV_STAGES = 64;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_MISALIGN = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_COUNT    = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] disk_byte_offset;
    logic [63:0] host_address;
    logic [63:0] byte_size;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        staged;
    logic [63:0] start_lba;
    logic [31:0] block_count;
    logic [63:0] buffer_offset;
    logic [63:0] byte_length;
    logic        last;
  } out_t;

  // one restoring-division lane: partial remainder and dividend/quotient word
  typedef struct packed {
    logic [16:0] rem;
    logic [63:0] word;
  } div_lane_t;

  typedef struct packed {
    logic [63:0] q_disk;
    logic [16:0] r_disk;
    logic [16:0] r_addr;
    logic [63:0] q_size;
    logic [16:0] r_size;
    logic [63:0] size;
  } div_res_t;

  function automatic div_lane_t div_step(div_lane_t a, logic [16:0] d);
    logic [17:0] t;
    logic        ge;
    div_lane_t   r;
    t      = {a.rem, a.word[63]};
    ge     = (t >= {1'b0, d});
    r.word = {a.word[62:0], ge};
    r.rem  = ge ? 17'(t - {1'b0, d}) : t[16:0];
    return r;
  endfunction

endpackage

// ===== src/bais_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, three lanes
module bais_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  bais_pkg::in_t     in_item,
  input  logic [16:0]       divisor,
  output logic              res_valid,
  output bais_pkg::div_res_t res
);

  logic                  valid    [1:bais_pkg::DIV_STAGES];
  bais_pkg::div_lane_t   disk_l   [1:bais_pkg::DIV_STAGES];
  bais_pkg::div_lane_t   addr_l   [1:bais_pkg::DIV_STAGES];
  bais_pkg::div_lane_t   size_l   [1:bais_pkg::DIV_STAGES];
  logic [63:0]           size_raw [1:bais_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= bais_pkg::DIV_STAGES; k++) valid[k] <= 1'b0;
    end else if (adv) begin
      valid[1] <= in_valid;
      for (int k = 2; k <= bais_pkg::DIV_STAGES; k++) valid[k] <= valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      disk_l[1]   <= bais_pkg::div_step({17'd0, in_item.disk_byte_offset}, divisor);
      addr_l[1]   <= bais_pkg::div_step({17'd0, in_item.host_address}, divisor);
      size_l[1]   <= bais_pkg::div_step({17'd0, in_item.byte_size}, divisor);
      size_raw[1] <= in_item.byte_size;
      for (int k = 2; k <= bais_pkg::DIV_STAGES; k++) begin
        disk_l[k]   <= bais_pkg::div_step(disk_l[k-1], divisor);
        addr_l[k]   <= bais_pkg::div_step(addr_l[k-1], divisor);
        size_l[k]   <= bais_pkg::div_step(size_l[k-1], divisor);
        size_raw[k] <= size_raw[k-1];
      end
    end
  end

  assign res_valid  = valid[bais_pkg::DIV_STAGES];
  assign res.q_disk = disk_l[bais_pkg::DIV_STAGES].word;
  assign res.r_disk = disk_l[bais_pkg::DIV_STAGES].rem;
  assign res.r_addr = addr_l[bais_pkg::DIV_STAGES].rem;
  assign res.q_size = size_l[bais_pkg::DIV_STAGES].word;
  assign res.r_size = size_l[bais_pkg::DIV_STAGES].rem;
  assign res.size   = size_raw[bais_pkg::DIV_STAGES];

endmodule

// ===== src/block_aligned_io_splitter.sv =====
// Block-aligned I/O splitter: turns one transfer request into one or two block-device
// segments (or one rejection) using the configured block size. Requests enter at one per
// cycle unless the emit stage stalls the pipeline; they pass the 64-stage bit-serial
// divider pipeline, two checking stages and the output register. A request that yields
// two segments holds the emit stage and stalls the pipeline until its second is loaded.
// Write block_bytes only while the block is empty.
module block_aligned_io_splitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            block_bytes_we,
  input  logic [16:0]     block_bytes_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  bais_pkg::in_t   in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output bais_pkg::out_t  out_item
);

  typedef struct packed {
    logic        zero;
    logic        mis_disk;
    logic        amis;
    logic        tail_nz;
    logic [63:0] head;
    logic [64:0] cnt;
    logic [31:0] hblk;
    logic [63:0] lba;
    logic [63:0] lba2;
    logic [63:0] size;
    logic [16:0] tail;
  } chk_t;

  typedef struct packed {
    bais_pkg::status_t status;
    logic        amis;
    logic        tail_nz;
    logic        head_nz;
    logic [31:0] cnt;
    logic [31:0] hblk;
    logic [63:0] head;
    logic [63:0] lba;
    logic [63:0] lba2;
    logic [63:0] size;
    logic [16:0] tail;
  } emit_t;

  logic [16:0]        block_bytes;
  logic               adv;
  logic               d_valid;
  bais_pkg::div_res_t d_res;
  logic               c_valid;
  chk_t               c;
  chk_t               c_next;
  logic               e_valid;
  emit_t              e;
  emit_t              e_next;
  logic               e_phase;
  logic               e_two;
  logic               o_load;
  logic               e_pop;
  logic [64:0]        pad_sum;
  bais_pkg::out_t     res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= 17'd512;
    end else if (block_bytes_we) begin
      block_bytes <= block_bytes_wdata;
    end
  end

  // whole pipeline moves together; held only by the emit stage
  assign e_two    = e.status == bais_pkg::ST_OK && !e.amis && e.head_nz && e.tail_nz;
  assign o_load   = e_valid && (!out_valid || out_ready);
  assign e_pop    = o_load && (!e_two || e_phase);
  assign adv      = !e_valid || e_pop;
  assign in_ready = adv;

  bais_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .divisor   (block_bytes),
    .res_valid (d_valid),
    .res       (d_res)
  );

  always_comb begin
    c_next.zero     = block_bytes == 17'd0 || d_res.size == 64'd0;
    c_next.mis_disk = d_res.r_disk != 17'd0;
    c_next.amis     = d_res.r_addr != 17'd0;
    c_next.tail_nz  = d_res.r_size != 17'd0;
    c_next.head     = d_res.size - {47'd0, d_res.r_size};
    c_next.cnt      = {1'b0, d_res.q_size} + {64'd0, d_res.r_size != 17'd0};
    c_next.hblk     = d_res.q_size[31:0];
    c_next.lba      = d_res.q_disk;
    c_next.lba2     = d_res.q_disk + d_res.q_size;
    c_next.size     = d_res.size;
    c_next.tail     = d_res.r_size;
  end

  always_comb begin
    pad_sum = {1'b0, c.head} + {48'd0, block_bytes};
    if (c.zero) begin
      e_next.status = bais_pkg::ST_ZERO;
    end else if (c.mis_disk) begin
      e_next.status = bais_pkg::ST_MISALIGN;
    end else if (c.tail_nz && pad_sum[64]) begin
      e_next.status = bais_pkg::ST_OVERFLOW;
    end else if (c.cnt[64:32] != 33'd0) begin
      e_next.status = bais_pkg::ST_COUNT;
    end else begin
      e_next.status = bais_pkg::ST_OK;
    end
    e_next.amis    = c.amis;
    e_next.tail_nz = c.tail_nz;
    e_next.head_nz = c.head != 64'd0;
    e_next.cnt     = c.cnt[31:0];
    e_next.hblk    = c.hblk;
    e_next.head    = c.head;
    e_next.lba     = c.lba;
    e_next.lba2    = c.lba2;
    e_next.size    = c.size;
    e_next.tail    = c.tail;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= d_valid;
      e_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c <= c_next;
      e <= e_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_phase <= 1'b0;
    end else if (e_pop) begin
      e_phase <= 1'b0;
    end else if (o_load && e_two) begin
      e_phase <= 1'b1;
    end
  end

  always_comb begin
    res_next = '0;
    res_next.status = e.status;
    if (e.status != bais_pkg::ST_OK) begin
      res_next.last = 1'b1;
    end else if (e.amis) begin
      res_next.staged        = 1'b1;
      res_next.start_lba     = e.lba;
      res_next.block_count   = e.cnt;
      res_next.byte_length   = e.size;
      res_next.last          = 1'b1;
    end else if (e.head_nz && !e_phase) begin
      res_next.start_lba     = e.lba;
      res_next.block_count   = e.hblk;
      res_next.byte_length   = e.head;
      res_next.last          = !e.tail_nz;
    end else begin
      // partial trailing block through the bounce buffer
      res_next.staged        = 1'b1;
      res_next.start_lba     = e.lba2;
      res_next.block_count   = 32'd1;
      res_next.buffer_offset = e.head;
      res_next.byte_length   = {47'd0, e.tail};
      res_next.last          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_item <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_two : assert property (@(posedge clk) disable iff (rst)
    e_phase |-> e_valid && e_two)
    else $error("second segment phase without a two-segment item");

  a_err_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != bais_pkg::ST_OK |-> out_item.last)
    else $error("rejection not marked last");

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != bais_pkg::ST_OK |->
      !out_item.staged && out_item.block_count == 32'd0 && out_item.byte_length == 64'd0)
    else $error("rejection carries segment data");
`endif

endmodule
